FILE: src/slpd_pkg.sv
// Shared types and constants for the sync/length packet deframer.
// Holds the result item layout and the configuration register indexes.
// No dependencies.
package slpd_pkg;

    localparam int unsigned BYTE_W     = 8;
    localparam int unsigned CFG_IDX_W  = 2;

    // Header length: two sync bytes and one length byte
    localparam logic [BYTE_W-1:0] HEADER_BYTES = 8'd3;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SYNC_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH  = 2'd2;

    // Register reset values
    localparam logic [BYTE_W-1:0] SYNC_FIRST_RST  = 8'd0;
    localparam logic [BYTE_W-1:0] SYNC_SECOND_RST = 8'd0;
    localparam logic [BYTE_W-1:0] MAX_LENGTH_RST  = 8'd255;

    // One result item
    typedef struct packed {
        logic [BYTE_W-1:0] packet_byte;
        logic [BYTE_W-1:0] byte_index;
        logic [BYTE_W-1:0] packet_length;
        logic              last;
    } slpd_result_t;

    // Input register contents handed to the frame logic
    typedef struct packed {
        logic              valid;
        logic [BYTE_W-1:0] data;
    } slpd_in_t;

    // Result handed from the frame logic to the output register
    typedef struct packed {
        logic         valid;
        slpd_result_t res;
    } slpd_res_t;

endpackage

FILE: src/slpd_in_stage.sv
// Input register of the deframer: captures one received byte per item.
// Depends on slpd_pkg for the byte width and the input struct.
module slpd_in_stage
    import slpd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [BYTE_W-1:0] rx_byte,
    input  logic              consume,
    output slpd_in_t          held
);

    logic              valid_reg;
    logic              valid_next;
    logic [BYTE_W-1:0] data_reg;
    logic              accept;

    // Take a new item when empty or when the held one leaves this cycle
    assign in_ready   = !valid_reg || consume;
    assign accept     = in_valid && in_ready;
    assign valid_next = accept || (valid_reg && !consume);

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture the byte
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            data_reg <= rx_byte;
        end
    end

    assign held.valid = valid_reg;
    assign held.data  = data_reg;

endmodule

FILE: src/slpd_frame.sv
// Frame tracking for the deframer: configuration registers, sync hunt,
// length check, header emission one byte at a time and body indexing.
// Depends on slpd_pkg for the result and input structs.
module slpd_frame
    import slpd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    input  slpd_in_t             held,
    input  logic                 out_free,
    output logic                 consume,
    output slpd_res_t            result
);

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_GOT_FIRST,
        PH_GET_LENGTH,
        PH_BODY
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic [BYTE_W-1:0] cur_len_reg, cur_len_next;
    logic [BYTE_W-1:0] next_idx_reg, next_idx_next;
    logic [1:0]        hdr_cnt_reg, hdr_cnt_next;
    logic [BYTE_W-1:0] sync_first_reg;
    logic [BYTE_W-1:0] sync_second_reg;
    logic [BYTE_W-1:0] max_len_reg;

    logic              bad_len;
    logic              body_fin;
    logic [BYTE_W:0]   idx_plus1;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sync_first_reg  <= SYNC_FIRST_RST;
            sync_second_reg <= SYNC_SECOND_RST;
            max_len_reg     <= MAX_LENGTH_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SYNC_FIRST:  sync_first_reg  <= cfg_data;
                CFG_SYNC_SECOND: sync_second_reg <= cfg_data;
                CFG_MAX_LENGTH:  max_len_reg     <= cfg_data;
                default:         ;
            endcase
        end
    end

    assign bad_len   = (held.data < HEADER_BYTES) || (held.data > max_len_reg);
    assign idx_plus1 = {1'b0, next_idx_reg} + {{BYTE_W{1'b0}}, 1'b1};
    assign body_fin  = idx_plus1 >= {1'b0, cur_len_reg};

    // Decode the held byte against the frame phase
    always_comb
    begin
        phase_next    = phase_reg;
        cur_len_next  = cur_len_reg;
        next_idx_next = next_idx_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        consume       = 1'b0;
        result        = '0;

        case (phase_reg)
            PH_HUNT:
            begin
                consume = held.valid;
                if (held.valid && (held.data == sync_first_reg))
                begin
                    phase_next = PH_GOT_FIRST;
                end
            end
            PH_GOT_FIRST:
            begin
                consume = held.valid;
                if (held.valid)
                begin
                    if (held.data == sync_second_reg)
                    begin
                        phase_next = PH_GET_LENGTH;
                    end
                    else if (held.data != sync_first_reg)
                    begin
                        phase_next = PH_HUNT;
                    end
                end
            end
            PH_GET_LENGTH:
            begin
                if (held.valid && bad_len)
                begin
                    // Drop the candidate, no results
                    consume    = 1'b1;
                    phase_next = PH_HUNT;
                end
                else if (held.valid && out_free)
                begin
                    // Emit one header byte per cycle while the output slot is free
                    result.valid             = 1'b1;
                    result.res.byte_index    = {{(BYTE_W-2){1'b0}}, hdr_cnt_reg};
                    result.res.packet_length = held.data;
                    case (hdr_cnt_reg)
                        2'd0:    result.res.packet_byte = sync_first_reg;
                        2'd1:    result.res.packet_byte = sync_second_reg;
                        default: result.res.packet_byte = held.data;
                    endcase
                    if (hdr_cnt_reg == 2'd2)
                    begin
                        consume         = 1'b1;
                        hdr_cnt_next    = 2'd0;
                        cur_len_next    = held.data;
                        result.res.last = (held.data == HEADER_BYTES);
                        if (held.data == HEADER_BYTES)
                        begin
                            phase_next    = PH_HUNT;
                            next_idx_next = '0;
                        end
                        else
                        begin
                            phase_next    = PH_BODY;
                            next_idx_next = HEADER_BYTES;
                        end
                    end
                    else
                    begin
                        hdr_cnt_next = hdr_cnt_reg + 2'd1;
                    end
                end
            end
            default:
            begin
                if (held.valid && out_free)
                begin
                    // Emit one body byte and advance the index
                    consume                  = 1'b1;
                    result.valid             = 1'b1;
                    result.res.packet_byte   = held.data;
                    result.res.byte_index    = next_idx_reg;
                    result.res.packet_length = cur_len_reg;
                    result.res.last          = body_fin;
                    if (body_fin)
                    begin
                        phase_next    = PH_HUNT;
                        next_idx_next = '0;
                    end
                    else
                    begin
                        next_idx_next = idx_plus1[BYTE_W-1:0];
                    end
                end
            end
        endcase
    end

    // Hold frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HUNT;
            cur_len_reg  <= '0;
            next_idx_reg <= '0;
            hdr_cnt_reg  <= 2'd0;
        end
        else
        begin
            phase_reg    <= phase_next;
            cur_len_reg  <= cur_len_next;
            next_idx_reg <= next_idx_next;
            hdr_cnt_reg  <= hdr_cnt_next;
        end
    end

endmodule

FILE: src/slpd_out_stage.sv
// Output register of the deframer: holds one result item until taken.
// Depends on slpd_pkg for the result structs.
module slpd_out_stage
    import slpd_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  slpd_res_t    result,
    output logic         out_free,
    output logic         out_valid,
    input  logic         out_ready,
    output slpd_result_t out_res
);

    logic         valid_reg;
    logic         valid_next;
    slpd_result_t res_reg;

    // Slot is free when empty or when the held item leaves this cycle
    assign out_free   = !valid_reg || out_ready;
    assign valid_next = result.valid || (valid_reg && !out_ready);

    // Hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Load a new result
    always_ff @(posedge clk)
    begin
        if (result.valid)
        begin
            res_reg <= result.res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

FILE: src/sync_length_packet_deframer_top.sv
// Top level of the sync/length packet deframer.
// Instantiates slpd_in_stage, slpd_frame and slpd_out_stage; uses slpd_pkg.
//
// Usage:
//   Input channel (in_valid/in_ready, rx_byte) takes one received byte per
//   item. Output channel (out_valid/out_ready) delivers packet bytes with
//   byte_index, packet_length and last. Registers are written through
//   cfg_we/cfg_index/cfg_data: 0 sync_first, 1 sync_second,
//   2 max_packet_length; index 3 is ignored.
//   Each byte passes through the input register and the frame logic, and
//   each result is held in the output register. Throughput is one byte per
//   cycle while the receiver keeps up; a valid length byte occupies the
//   frame stage while the sync bytes and the length byte are sent one per
//   cycle through the single output register. Sync, hunt and rejected length
//   bytes produce no result and are consumed without needing the output slot.
//   Reset clears both pipeline registers, returns to hunting for the first
//   sync byte and loads the register defaults (0, 0, 255).
//   When the receiver stalls, the output item holds, the frame stage holds
//   a header or body byte, and in_ready drops once the input register is full.
module sync_length_packet_deframer_top
    import slpd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [BYTE_W-1:0]    rx_byte,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [BYTE_W-1:0]    packet_byte,
    output logic [BYTE_W-1:0]    byte_index,
    output logic [BYTE_W-1:0]    packet_length,
    output logic                 last
);

    slpd_in_t     held;
    slpd_res_t    result;
    slpd_result_t out_res;
    logic         consume;
    logic         out_free;

    slpd_in_stage u_in (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .rx_byte  (rx_byte),
        .consume  (consume),
        .held     (held)
    );

    slpd_frame u_frame (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .held      (held),
        .out_free  (out_free),
        .consume   (consume),
        .result    (result)
    );

    slpd_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .result    (result),
        .out_free  (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign packet_byte   = out_res.packet_byte;
    assign byte_index    = out_res.byte_index;
    assign packet_length = out_res.packet_length;
    assign last          = out_res.last;

endmodule

FILE: dv/slpd_packet_checker.sv
// Scoreboard for the sync/length packet deframer: follows register writes, deframes
// every accepted received byte and compares each delivered packet byte in order.
// Depends on slpd_pkg.
module slpd_packet_checker
    import slpd_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [BYTE_W-1:0]    cfg_data,
    input  logic                 in_valid,
    input  logic                 in_ready,
    input  logic [BYTE_W-1:0]    rx_byte,
    input  logic                 out_valid,
    input  logic                 out_ready,
    input  logic [BYTE_W-1:0]    packet_byte,
    input  logic [BYTE_W-1:0]    byte_index,
    input  logic [BYTE_W-1:0]    packet_length,
    input  logic                 last,
    output int                   mismatch_count,
    output int                   pending_results
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef enum logic [1:0] {
        HUNT_FIRST,
        SEEN_FIRST,
        AWAIT_LENGTH,
        IN_BODY
    } frame_state_t;

    // Register copies
    logic [BYTE_W-1:0] sync_first_q;
    logic [BYTE_W-1:0] sync_second_q;
    logic [BYTE_W-1:0] max_length_q;

    // Framing state
    frame_state_t      frame_state;
    logic [BYTE_W-1:0] body_length;
    logic [BYTE_W-1:0] body_index;

    slpd_result_t expected_packet_bytes [$];

    // Queue one expected packet byte
    task automatic push_packet_byte(input logic [BYTE_W-1:0] value,
                                    input logic [BYTE_W-1:0] index,
                                    input logic [BYTE_W-1:0] length,
                                    input logic              is_last);
        slpd_result_t r;
        r.packet_byte   = value;
        r.byte_index    = index;
        r.packet_length = length;
        r.last          = is_last;
        expected_packet_bytes.push_back(r);
    endtask

    // Advance the framing state by one received byte
    task automatic deframe_byte(input logic [BYTE_W-1:0] b);
        logic fin;
        case (frame_state)
            HUNT_FIRST:
            begin
                if (b == sync_first_q)
                    frame_state = SEEN_FIRST;
            end
            SEEN_FIRST:
            begin
                // second sync is tested first; a repeated first sync keeps the phase
                if (b == sync_second_q)
                    frame_state = AWAIT_LENGTH;
                else if (b != sync_first_q)
                    frame_state = HUNT_FIRST;
            end
            AWAIT_LENGTH:
            begin
                if (b < HEADER_BYTES || b > max_length_q)
                begin
                    // drop the candidate, resume hunting with the next byte
                    frame_state = HUNT_FIRST;
                end
                else
                begin
                    fin = (b == HEADER_BYTES);
                    push_packet_byte(sync_first_q, 8'd0, b, 1'b0);
                    push_packet_byte(sync_second_q, 8'd1, b, 1'b0);
                    push_packet_byte(b, 8'd2, b, fin);
                    body_length = b;
                    if (fin)
                    begin
                        frame_state = HUNT_FIRST;
                        body_index  = '0;
                    end
                    else
                    begin
                        frame_state = IN_BODY;
                        body_index  = HEADER_BYTES;
                    end
                end
            end
            default:
            begin
                fin = (int'(body_index) + 1 >= int'(body_length));
                push_packet_byte(b, body_index, body_length, fin);
                if (fin)
                begin
                    frame_state = HUNT_FIRST;
                    body_index  = '0;
                end
                else
                begin
                    body_index = body_index + 8'd1;
                end
            end
        endcase
    endtask

    // Report one field that differs from its expectation
    function automatic bit field_differs(input string field, input logic [BYTE_W-1:0] want,
                                         input logic [BYTE_W-1:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, field, want, got);
            return 1'b1;
        end
        return 1'b0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        slpd_result_t want;
        bit           bad;
        if (!rst_n)
        begin
            sync_first_q    = SYNC_FIRST_RST;
            sync_second_q   = SYNC_SECOND_RST;
            max_length_q    = MAX_LENGTH_RST;
            frame_state     = HUNT_FIRST;
            body_length     = '0;
            body_index      = '0;
            mismatch_count  = 0;
            expected_packet_bytes.delete();
            pending_results <= 0;
        end
        else
        begin
            // check the delivered item against the oldest expectation
            if (out_valid && out_ready)
            begin
                if (expected_packet_bytes.size() == 0)
                begin
                    $display({"%0t: unexpected packet byte, expected none, ",
                              "got %0h idx %0d len %0d last %0b"},
                             $time, packet_byte, byte_index, packet_length, last);
                    mismatch_count++;
                end
                else
                begin
                    want = expected_packet_bytes.pop_front();
                    bad  = field_differs("packet_byte", want.packet_byte, packet_byte)
                         | field_differs("byte_index", want.byte_index, byte_index)
                         | field_differs("packet_length", want.packet_length, packet_length)
                         | field_differs("last", {7'd0, want.last}, {7'd0, last});
                    if (bad)
                        mismatch_count++;
                end
            end

            // predict results of the accepted item
            if (in_valid && in_ready)
                deframe_byte(rx_byte);

            // follow register writes; unknown indexes are ignored
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SYNC_FIRST:  sync_first_q  = cfg_data;
                    CFG_SYNC_SECOND: sync_second_q = cfg_data;
                    CFG_MAX_LENGTH:  max_length_q  = cfg_data;
                    default: ;
                endcase
            end

            pending_results <= expected_packet_bytes.size();
        end
    end

endmodule

FILE: dv/sync_length_packet_deframer_top_tb.sv
// Testbench top for the sync/length packet deframer: clock, reset, register setup,
// received-byte stimulus, receiver back-pressure and the verdict.
// Depends on slpd_pkg, sync_length_packet_deframer_top and slpd_packet_checker.
module sync_length_packet_deframer_top_tb;
    import slpd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
    localparam int HOLD_OFF_CYCLES = 200;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [BYTE_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [BYTE_W-1:0]    rx_byte;
    logic                 out_valid;
    logic                 out_ready;
    logic [BYTE_W-1:0]    packet_byte;
    logic [BYTE_W-1:0]    byte_index;
    logic [BYTE_W-1:0]    packet_length;
    logic                 last;
    int                   mismatch_count;
    int                   pending_results;

    // Stimulus-side copies of the registers
    logic [BYTE_W-1:0] sync_first_cfg;
    logic [BYTE_W-1:0] sync_second_cfg;
    logic [BYTE_W-1:0] max_length_cfg;

    int send_idle_pct;
    int recv_idle_pct;
    int items_sent;
    bit hold_off_req;

    sync_length_packet_deframer_top DUT (.*);

    slpd_packet_checker u_checker (.*);

    // Clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // Limit the run
    initial
    begin
        #2_000_000;
        $display("[sync_length_packet_deframer_top] ERROR");
        $finish;
    end

    // Receiver: random stalls, one long hold-off on request
    initial
    begin
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                hold_off_req = 1'b0;
                out_ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
            end
            out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    // Offer one item, idling at random first, and wait for its acceptance
    task automatic send_byte(input logic [BYTE_W-1:0] value);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte  <= value;
        do
            @(posedge clk);
        while (!in_ready);
        items_sent++;
    endtask

    // Send sync, length and, when the length is accepted, the body
    task automatic send_packet(input int len);
        send_byte(sync_first_cfg);
        send_byte(sync_second_cfg);
        send_byte(len[BYTE_W-1:0]);
        if (len >= int'(HEADER_BYTES) && len <= int'(max_length_cfg))
            repeat (len - int'(HEADER_BYTES)) send_byte(8'($urandom_range(0, 255)));
    endtask

    // Stop offering and wait until every expected item has arrived
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending_results == 0);
        repeat (4) @(posedge clk);
    endtask

    // Write all registers; the block must be idle
    task automatic set_config(input logic [BYTE_W-1:0] first, input logic [BYTE_W-1:0] second,
                              input logic [BYTE_W-1:0] max_len, input bit touch_unused);
        cfg_we    <= 1'b1;
        cfg_index <= CFG_SYNC_FIRST;
        cfg_data  <= first;
        @(posedge clk);
        cfg_index <= CFG_SYNC_SECOND;
        cfg_data  <= second;
        @(posedge clk);
        cfg_index <= CFG_MAX_LENGTH;
        cfg_data  <= max_len;
        @(posedge clk);
        if (touch_unused)
        begin
            cfg_index <= CFG_UNUSED;
            cfg_data  <= 8'($urandom_range(0, 255));
            @(posedge clk);
        end
        cfg_we          <= 1'b0;
        sync_first_cfg  = first;
        sync_second_cfg = second;
        max_length_cfg  = max_len;
    endtask

    // Mostly well-formed packets with random content, plus noise, broken starts and rejected lengths
    task automatic run_packets(input int budget);
        int stop_at;
        int choice;
        int upper;
        int len;
        stop_at = items_sent + budget;
        while (items_sent < stop_at)
        begin
            repeat ($urandom_range(0, 2)) send_byte(8'($urandom_range(0, 255)));
            choice = $urandom_range(0, 99);
            if (choice < 8)
            begin
                // broken start
                send_byte(sync_first_cfg);
                send_byte(8'($urandom_range(0, 255)));
            end
            else if (choice < 18 || max_length_cfg < HEADER_BYTES)
            begin
                // rejected length
                if (max_length_cfg < 8'd255 && $urandom_range(0, 1))
                    len = $urandom_range(int'(max_length_cfg) + 1, 255);
                else
                    len = $urandom_range(0, 2);
                send_packet(len);
            end
            else
            begin
                upper = (max_length_cfg < 8'd12) ? int'(max_length_cfg) : 12;
                if ($urandom_range(0, 29) == 0)
                    upper = int'(max_length_cfg);
                send_packet($urandom_range(int'(HEADER_BYTES), upper));
            end
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        logic [BYTE_W-1:0] directed_seq [25];
        directed_seq = '{
            8'hA5, 8'hA5, 8'h5A, 8'h03,          // overlapping start, minimal packet
            8'hA5, 8'h5A, 8'h02,                 // length too short
            8'hA5, 8'h5A, 8'h07,                 // length over the maximum
            8'hA5, 8'h5A, 8'hA5, 8'h5A, 8'h03,   // rejected length is not a new start
            8'hA5, 8'h5A, 8'h06, 8'hFF, 8'h00, 8'h80, // longest allowed packet
            8'h00, 8'hFF,                        // hunting noise
            8'hA5, 8'h01                         // first sync then a mismatch
        };
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_index     = CFG_SYNC_FIRST;
        cfg_data      = '0;
        in_valid      = 1'b0;
        rx_byte       = '0;
        hold_off_req  = 1'b0;
        items_sent    = 0;
        send_idle_pct = 23;
        recv_idle_pct = 58;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed part
        set_config(8'hA5, 8'h5A, 8'd6, 1'b1);
        foreach (directed_seq[i])
            send_byte(directed_seq[i]);
        drain();

        // extreme sync values, full length range
        set_config(8'hFF, 8'h00, 8'd255, 1'b0);
        run_packets(40);
        drain();

        // equal sync bytes, smallest useful maximum
        send_idle_pct = 58;
        recv_idle_pct = 23;
        set_config(8'h3C, 8'h3C, HEADER_BYTES, 1'b0);
        run_packets(60);
        drain();

        // maximum below the header size: every length is rejected
        set_config(8'h00, 8'h00, 8'd2, 1'b0);
        run_packets(15);
        drain();
        set_config(8'h00, 8'h00, 8'd0, 1'b0);
        run_packets(15);
        drain();

        // no idling, long receiver hold-off, then a full pause
        send_idle_pct = 0;
        recv_idle_pct = 0;
        set_config(8'h00, 8'hFF, 8'd40, 1'b0);
        run_packets(40);
        hold_off_req = 1'b1;
        send_packet(30);
        run_packets(20);
        in_valid <= 1'b0;
        @(posedge clk);
        wait (pending_results == 0);
        run_packets(40);

        drain();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && pending_results == 0)
            $display("[sync_length_packet_deframer_top] OK");
        else
            $display("[sync_length_packet_deframer_top] ERROR");
        $finish;
    end

endmodule

FILE: sync_length_packet_deframer_top.f
src/slpd_pkg.sv
src/slpd_in_stage.sv
src/slpd_frame.sv
src/slpd_out_stage.sv
src/sync_length_packet_deframer_top.sv
dv/slpd_packet_checker.sv
dv/sync_length_packet_deframer_top_tb.sv
